@@ design/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

	localparam int CntW = 26;

	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_SEND  = 3'd3;
	localparam logic [2:0] CMD_RECV  = 3'd4;

	localparam logic [2:0] PRIM_IDLE = 3'd0;

	localparam logic [1:0] REG_SLOW_FACTOR = 2'd0;
	localparam logic [1:0] REG_LONG_DELAY  = 2'd1;
	localparam logic [1:0] REG_SHORT_DELAY = 2'd2;

	localparam logic [15:0] SLOW_RST  = 16'd1;
	localparam logic [9:0]  LONG_RST  = 10'd60;
	localparam logic [9:0]  SHORT_RST = 10'd40;

	typedef struct packed {
		logic [CntW-1:0] long_len;
		logic [CntW-1:0] short_len;
	} phase_len_t;

endpackage

@@ design/i2cm_cfg.sv @@
// Configuration registers and premultiplied phase lengths.
module i2cm_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output i2cm_pkg::phase_len_t lens
);

	logic [15:0] slow_q;
	logic [9:0]  long_q;
	logic [9:0]  short_q;
	i2cm_pkg::phase_len_t lens_q;

	logic [15:0] slow_nx;
	logic [15:0] slow_eff;
	logic [9:0]  long_nx;
	logic [9:0]  short_nx;

	always_comb begin
		slow_nx  = (cfg_index == i2cm_pkg::REG_SLOW_FACTOR) ? cfg_data : slow_q;
		long_nx  = (cfg_index == i2cm_pkg::REG_LONG_DELAY) ? cfg_data[9:0] : long_q;
		short_nx = (cfg_index == i2cm_pkg::REG_SHORT_DELAY) ? cfg_data[9:0] : short_q;
		slow_eff = (slow_nx == 16'd0) ? 16'd1 : slow_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q           <= i2cm_pkg::SLOW_RST;
			long_q           <= i2cm_pkg::LONG_RST;
			short_q          <= i2cm_pkg::SHORT_RST;
			lens_q.long_len  <= i2cm_pkg::CntW'(i2cm_pkg::LONG_RST);
			lens_q.short_len <= i2cm_pkg::CntW'(i2cm_pkg::SHORT_RST);
		end else if (cfg_valid) begin
			slow_q           <= slow_nx;
			long_q           <= long_nx;
			short_q          <= short_nx;
			lens_q.long_len  <= i2cm_pkg::CntW'({16'd0, long_nx} * {10'd0, slow_eff});
			lens_q.short_len <= i2cm_pkg::CntW'({16'd0, short_nx} * {10'd0, slow_eff});
		end
	end

	assign lens = lens_q;

endmodule

@@ design/i2c_master_bit_engine.sv @@
// I2C master bit engine top level: tick handshake, primitive sequencer, result register.
// One bus tick per item, one item per clock. The sequencer state advances through combinational
// next-state logic and each result sits in an output register, so an item is
// taken whenever that register is empty or being drained. Phase lengths (delay times
// slow factor) are multiplied once when a register is written, so each tick only adds
// one to the phase counter and compares it with the stored length.
module i2c_master_bit_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  tx_byte,
	input  logic        ack_out,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic        ack_seen,
	output logic [7:0]  rx_byte,
	output logic        rejected,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CntW = i2cm_pkg::CntW;

	i2cm_pkg::phase_len_t lens;

	logic [2:0]      prim_q;
	logic [2:0]      step_q;
	logic [3:0]      bidx_q;
	logic [7:0]      tx_q;
	logic [7:0]      rx_q;
	logic [CntW-1:0] cnt_q;
	logic            scl_q;
	logic            sda_q;
	logic            ack_q;
	logic            acko_q;

	logic            out_valid_q;
	logic            scl_out_q, sda_out_q, busy_q, done_q, rej_q;

	logic [2:0]      prim_d;
	logic [2:0]      step_d;
	logic [3:0]      bidx_d;
	logic [7:0]      tx_d;
	logic [7:0]      rx_d;
	logic [CntW-1:0] cnt_d;
	logic [CntW-1:0] cnt_inc;
	logic            scl_d, sda_d, ack_d, acko_d;
	logic            pin_scl, pin_sda, rej_d, done_d, lng, fin;

	logic in_xfer;

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lens      (lens)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;

	always_comb begin
		prim_d  = prim_q;
		step_d  = step_q;
		bidx_d  = bidx_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		cnt_d   = cnt_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		acko_d  = acko_q;
		rej_d   = 1'b0;
		done_d  = 1'b0;
		lng     = 1'b0;
		fin     = 1'b0;
		cnt_inc = '0;

		if (cmd == i2cm_pkg::CMD_START || cmd == i2cm_pkg::CMD_STOP ||
		    cmd == i2cm_pkg::CMD_SEND || cmd == i2cm_pkg::CMD_RECV) begin
			if (prim_q != i2cm_pkg::PRIM_IDLE) begin
				rej_d = 1'b1;
			end else begin
				prim_d = cmd;
				step_d = 3'd0;
				bidx_d = 4'd0;
				cnt_d  = '0;
				acko_d = ack_out;
				if (cmd == i2cm_pkg::CMD_SEND) tx_d = tx_byte;
				if (cmd == i2cm_pkg::CMD_RECV) begin
					rx_d  = 8'd0;
					sda_d = 1'b1;
				end
			end
		end

		// drive levels for this phase
		if (prim_d != i2cm_pkg::PRIM_IDLE) begin
			unique case (prim_d)
				i2cm_pkg::CMD_START: begin
					if (step_d == 3'd0) begin
						sda_d = 1'b1; scl_d = 1'b1; lng = 1'b1;
					end else if (step_d == 3'd1) begin
						sda_d = 1'b0; lng = 1'b1;
					end else begin
						scl_d = 1'b0;
					end
				end
				i2cm_pkg::CMD_STOP: begin
					if (step_d == 3'd0) begin
						sda_d = 1'b0;
					end else if (step_d == 3'd1) begin
						scl_d = 1'b1; lng = 1'b1;
					end else begin
						sda_d = 1'b1; lng = 1'b1;
					end
				end
				i2cm_pkg::CMD_SEND: begin
					if (step_d == 3'd0) begin
						sda_d = (bidx_d < 4'd8) ? tx_d[7] : 1'b1;
					end else if (step_d == 3'd1) begin
						scl_d = 1'b1; lng = 1'b1;
					end else begin
						scl_d = 1'b0;
					end
				end
				default: begin
					if (step_d == 3'd0) begin
						scl_d = 1'b1; lng = 1'b1;
					end else if (step_d == 3'd1) begin
						scl_d = 1'b0;
					end else if (step_d == 3'd2) begin
						sda_d = !acko_d;
					end else if (step_d == 3'd3) begin
						scl_d = 1'b1; lng = 1'b1;
					end else begin
						scl_d = 1'b0;
					end
				end
			endcase
		end
		pin_scl = scl_d;
		pin_sda = sda_d;

		// phase timing and end of phase
		if (prim_d != i2cm_pkg::PRIM_IDLE) begin
			cnt_inc = cnt_d + 1'b1;
			if (cnt_inc >= (lng ? lens.long_len : lens.short_len)) begin
				cnt_d = '0;
				unique case (prim_d) inside
					i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: begin
						step_d = step_d + 3'd1;
						fin    = (step_d == 3'd3);
					end
					i2cm_pkg::CMD_SEND: begin
						if (step_d == 3'd1 && bidx_d == 4'd8) ack_d = !sda_in;
						if (step_d < 3'd2) begin
							step_d = step_d + 3'd1;
						end else begin
							if (bidx_d < 4'd8) tx_d = {tx_d[6:0], 1'b0};
							bidx_d = bidx_d + 4'd1;
							step_d = 3'd0;
							fin    = (bidx_d == 4'd9);
						end
					end
					default: begin
						if (step_d == 3'd0) begin
							rx_d   = {rx_d[6:0], sda_in};
							step_d = 3'd1;
						end else if (step_d == 3'd1) begin
							bidx_d = bidx_d + 4'd1;
							step_d = (bidx_d >= 4'd8) ? 3'd2 : 3'd0;
						end else if (step_d < 3'd4) begin
							step_d = step_d + 3'd1;
						end else begin
							sda_d = 1'b1;
							fin   = 1'b1;
						end
					end
				endcase
			end else begin
				cnt_d = cnt_inc;
			end
			if (fin) begin
				prim_d = i2cm_pkg::PRIM_IDLE;
				step_d = 3'd0;
				bidx_d = 4'd0;
				done_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_q <= i2cm_pkg::PRIM_IDLE;
			step_q <= 3'd0;
			bidx_q <= 4'd0;
			tx_q   <= 8'd0;
			rx_q   <= 8'd0;
			cnt_q  <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			ack_q  <= 1'b0;
			acko_q <= 1'b0;
		end else if (in_xfer) begin
			prim_q <= prim_d;
			step_q <= step_d;
			bidx_q <= bidx_d;
			tx_q   <= tx_d;
			rx_q   <= rx_d;
			cnt_q  <= cnt_d;
			scl_q  <= scl_d;
			sda_q  <= sda_d;
			ack_q  <= ack_d;
			acko_q <= acko_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			scl_out_q <= pin_scl;
			sda_out_q <= pin_sda;
			busy_q    <= (prim_d != i2cm_pkg::PRIM_IDLE);
			done_q    <= done_d;
			rej_q     <= rej_d;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = scl_out_q;
	assign sda_level = sda_out_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign rejected  = rej_q;
	assign ack_seen  = ack_q;
	assign rx_byte   = rx_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !busy_q)
		else $error("done reported while still busy");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		prim_q == i2cm_pkg::PRIM_IDLE |-> step_q == 3'd0 && bidx_q == 4'd0 && cnt_q == '0)
		else $error("idle sequencer holds stale phase state");

	a_bidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bidx_q <= 4'd9)
		else $error("bit index out of range");

	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && prim_q == i2cm_pkg::PRIM_IDLE &&
		(cmd == i2cm_pkg::CMD_START || cmd == i2cm_pkg::CMD_STOP ||
		 cmd == i2cm_pkg::CMD_SEND || cmd == i2cm_pkg::CMD_RECV)
		|=> prim_q == $past(cmd))
		else $error("accepted command did not start its primitive");

endmodule
